// ===== rtl/cfbi_pkg.sv =====
// Package for the CSV field boundary indexer: payload structs, record kinds
// and character codes. No dependencies.
package cfbi_pkg;

  // Fixed sizes of the index format; the record fields below are built for them.
  localparam int DELTA_BITS    = 16;
  localparam int MAX_COLUMNS   = 1024;
  localparam int POSITION_BITS = 32;

  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;

  localparam logic [1:0] KIND_ANCHOR = 2'd0;
  localparam logic [1:0] KIND_DELTA  = 2'd1;
  localparam logic [1:0] KIND_ROW    = 2'd2;

  localparam logic [1:0] LEM_CRLF = 2'd3;
  localparam logic [1:0] LEM_CR   = 2'd2;
  localparam logic [1:0] LEM_LF   = 2'd1;
  localparam logic [1:0] LEM_NONE = 2'd0;

  // Upper bound on the records one input word can cause.
  localparam int MAX_RES = 9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] position;
    logic [10:0] column;
    logic [15:0] delta;
    logic [10:0] repeat_res;
    logic [31:0] anchor_base;
    logic [10:0] anchor_count;
    logic        overflow_seen;
    logic        underflow_seen;
    logic        last_result;
  } out_t;

  function automatic out_t mk_rec(logic [1:0] kind, logic [31:0] pos, logic [10:0] col,
                                  logic [15:0] dlt, logic [10:0] rep, logic [31:0] base,
                                  logic [10:0] cnt, logic [1:0] flags);
    out_t r;
    r.kind           = kind;
    r.position       = pos;
    r.column         = col;
    r.delta          = dlt;
    r.repeat_res     = rep;
    r.anchor_base    = base;
    r.anchor_count   = cnt;
    r.overflow_seen  = flags[0];
    r.underflow_seen = flags[1];
    r.last_result    = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/cfbi_front.sv =====
// Front end of the CSV field boundary indexer: parses one byte per word,
// builds its records and hands them one at a time to the queue. Uses cfbi_pkg.
module cfbi_front import cfbi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic push,
  input  logic full,
  output out_t push_data
);

  localparam int P  = POSITION_BITS;
  localparam int CW = $clog2(MAX_COLUMNS + 2);

  logic [P-1:0]  pos_r, pos_nxt, anc_r, anc_nxt;
  logic          inq_r, inq_nxt, hdone_r, hdone_nxt, mpend_r, mpend_nxt, skip_r, skip_nxt;
  logic [7:0]    prev_r, prev_nxt, prev2_r, prev2_nxt;
  logic [CW-1:0] col_r, col_nxt, hcol_r, hcol_nxt;
  logic [1:0]    lem_r, lem_nxt, warn_r, warn_nxt;
  logic [31:0]   rab_r, rab_nxt;
  logic [10:0]   rac_r, rac_nxt;

  out_t          recs [MAX_RES];
  logic [3:0]    nrec;
  out_t          pend_r [MAX_RES];
  logic [3:0]    pcnt_r, pidx_r;
  logic          acc;

  assign push      = (pidx_r != pcnt_r) && !full;
  assign push_data = pend_r[pidx_r];
  assign in_ready  = (pidx_r == pcnt_r) || ((pcnt_r - pidx_r == 4'd1) && push);
  assign acc       = in_valid && in_ready;

  always_comb begin
    logic [7:0]    c;
    logic          eof, is_le, unq_le, le_close, do_close, rs;
    logic [P-1:0]  i, val, tgt, dsv;
    logic [CW-1:0] limit;
    c      = in_data.data_byte;
    eof    = in_data.end_of_file;
    i      = pos_r;
    is_le  = (c == CH_CR) || (c == CH_LF);
    unq_le = is_le && !inq_r;
    le_close = 1'b0;
    nrec   = '0;
    for (int k = 0; k < MAX_RES; k++) recs[k] = '0;
    pos_nxt = i + P'(1);
    anc_nxt = anc_r;  inq_nxt = inq_r;  hdone_nxt = hdone_r; mpend_nxt = mpend_r;
    skip_nxt = skip_r; prev_nxt = prev_r; prev2_nxt = prev2_r; col_nxt = col_r;
    hcol_nxt = hcol_r; lem_nxt = lem_r; warn_nxt = warn_r; rab_nxt = rab_r; rac_nxt = rac_r;
    val = '0; tgt = '0; dsv = '0;
    rs = 1'b0;
    limit = '0;

    if (!(skip_r && !is_le)) begin
      if (mpend_r) begin
        lem_nxt   = (c == CH_LF) ? LEM_CRLF : LEM_CR;
        mpend_nxt = 1'b0;
      end
      rs = (col_r == '0) && !inq_r && ((prev_r == CH_LF) || (prev_r == CH_CR)) &&
           (prev2_r != CH_CR);
      if (rs) begin
        val     = (lem_nxt == LEM_CRLF) ? i + P'(1) : i;
        anc_nxt = val;
        recs[nrec] = mk_rec(KIND_ANCHOR, 32'(val), 11'd0, 16'd0, 11'd0, 32'd0, 11'd0,
                            warn_nxt);
        nrec    = nrec + 4'd1;
        rab_nxt = rab_nxt + 32'(rac_nxt);
        rac_nxt = 11'd1;
        recs[nrec] = mk_rec(KIND_DELTA, 32'd0, 11'd0, 16'd0, 11'd1, 32'd0, 11'd0, warn_nxt);
        nrec    = nrec + 4'd1;
      end
      if (c == CH_QUOTE) begin
        inq_nxt = !inq_r;
      end else if (!inq_r && c == CH_COMMA) begin
        limit = hdone_r ? hcol_r : CW'(MAX_COLUMNS);
        val   = i + P'(1);
        tgt   = val - anc_nxt;
        if ((tgt >> DELTA_BITS) != '0) begin
          anc_nxt = val;
          recs[nrec] = mk_rec(KIND_ANCHOR, 32'(val), 11'(col_nxt + CW'(1)), 16'd0, 11'd0,
                              32'd0, 11'd0, warn_nxt);
          nrec    = nrec + 4'd1;
          rac_nxt = rac_nxt + 11'd1;
          tgt     = '0;
        end
        recs[nrec] = mk_rec(KIND_DELTA, 32'd0, 11'd0, 16'(tgt), 11'd1, 32'd0, 11'd0,
                            warn_nxt);
        nrec = nrec + 4'd1;
        if (col_nxt < limit) begin
          col_nxt = col_nxt + CW'(1);
        end else begin
          warn_nxt[0] = 1'b1;
          skip_nxt    = 1'b1;
        end
      end else if (!inq_r && c == CH_LF && prev_r == CH_CR) begin
        // second byte of a CRLF pair: nothing to do
      end else if (unq_le) begin
        le_close = 1'b1;
        if (lem_nxt == LEM_NONE && !mpend_nxt) begin
          if (c == CH_LF) lem_nxt = LEM_LF;
          else mpend_nxt = 1'b1;
        end
      end
      prev2_nxt = prev_r;
      prev_nxt  = c;
    end

    // Pass 0 closes on a line end, pass 1 on end of file.
    for (int pass = 0; pass < 2; pass++) begin
      do_close = (pass == 0) ? le_close : (eof && !unq_le);
      if (do_close) begin
        val = (pass == 0) ? i + P'(1) : i + P'(2);
        dsv = '0;
        if (skip_nxt) begin
          skip_nxt = 1'b0;
        end else begin
          tgt = val - anc_nxt;
          if ((tgt >> DELTA_BITS) != '0) begin
            anc_nxt = val;
            if (nrec < 4'(MAX_RES)) begin
              recs[nrec] = mk_rec(KIND_ANCHOR, 32'(val), 11'(col_nxt + CW'(1)), 16'd0,
                                  11'd0, 32'd0, 11'd0, warn_nxt);
              nrec = nrec + 4'd1;
            end
            rac_nxt = rac_nxt + 11'd1;
            tgt     = '0;
          end
          if (nrec < 4'(MAX_RES)) begin
            recs[nrec] = mk_rec(KIND_DELTA, 32'd0, 11'd0, 16'(tgt), 11'd1, 32'd0, 11'd0,
                                warn_nxt);
            nrec = nrec + 4'd1;
          end
          dsv = tgt;
        end
        if (!hdone_nxt) begin
          hcol_nxt  = col_nxt;
          hdone_nxt = 1'b1;
        end else if (col_nxt < hcol_nxt) begin
          warn_nxt[1] = 1'b1;
          if (nrec < 4'(MAX_RES)) begin
            recs[nrec] = mk_rec(KIND_DELTA, 32'd0, 11'd0, 16'(dsv), 11'(hcol_nxt - col_nxt),
                                32'd0, 11'd0, warn_nxt);
            nrec = nrec + 4'd1;
          end
        end
        if (nrec < 4'(MAX_RES)) begin
          recs[nrec] = mk_rec(KIND_ROW, 32'd0, 11'd0, 16'd0, 11'd0, rab_nxt, rac_nxt,
                              warn_nxt);
          nrec = nrec + 4'd1;
        end
        col_nxt = '0;
      end
    end

    if (nrec != '0) recs[nrec - 4'd1].last_result = 1'b1;

    if (eof) begin
      pos_nxt = '0; inq_nxt = 1'b0; prev_nxt = CH_LF; prev2_nxt = '0; col_nxt = '0;
      hcol_nxt = '0; hdone_nxt = 1'b0; lem_nxt = LEM_NONE; mpend_nxt = 1'b0; anc_nxt = '0;
      rab_nxt = '0; rac_nxt = '0; skip_nxt = 1'b0; warn_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; inq_r <= 1'b0; prev_r <= CH_LF; prev2_r <= '0; col_r <= '0;
      hcol_r <= '0; hdone_r <= 1'b0; lem_r <= LEM_NONE; mpend_r <= 1'b0; anc_r <= '0;
      rab_r <= '0; rac_r <= '0; skip_r <= 1'b0; warn_r <= '0;
      pcnt_r <= '0; pidx_r <= '0;
    end else if (acc) begin
      pos_r <= pos_nxt; inq_r <= inq_nxt; prev_r <= prev_nxt; prev2_r <= prev2_nxt;
      col_r <= col_nxt; hcol_r <= hcol_nxt; hdone_r <= hdone_nxt; lem_r <= lem_nxt;
      mpend_r <= mpend_nxt; anc_r <= anc_nxt; rab_r <= rab_nxt; rac_r <= rac_nxt;
      skip_r <= skip_nxt; warn_r <= warn_nxt;
      pcnt_r <= nrec; pidx_r <= '0;
    end else if (push) begin
      pidx_r <= pidx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int k = 0; k < MAX_RES; k++) pend_r[k] <= recs[k];
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pidx_r <= pcnt_r) else $error("drain index past record count");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= 4'(MAX_RES)) else $error("record count too large");
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    push && (pcnt_r - pidx_r == 4'd1) |-> push_data.last_result)
    else $error("final record of a word not marked last");

endmodule

// ===== rtl/cfbi_back.sv =====
// Back end of the CSV field boundary indexer: a four-entry record queue and
// the output register. Uses cfbi_pkg.
module cfbi_back import cfbi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  out_t push_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  out_t       q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       ov_r, pop, load;
  out_t       od_r;

  assign full      = (cnt_r == 3'd4);
  assign load      = !ov_r || out_ready;
  assign pop       = load && (cnt_r != 3'd0);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
      if (load) ov_r <= (cnt_r != 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_data;
    if (pop) od_r <= q_r[rp_r];
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("push into full queue");
  a_cnt_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("queue count out of range");
  a_ptr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd0 || cnt_r == 3'd4) |-> wp_r == rp_r) else $error("queue pointers skewed");

endmodule

// ===== rtl/csv_field_boundary_indexer_unit.sv =====
// Top level of the CSV field boundary indexer: front end parser plus back
// end queue. Uses cfbi_pkg, cfbi_front and cfbi_back.
//
//   Channel  Ports               Word type  Direction
//   input    in_valid/in_ready   in_t       byte of the file in
//   result   out_valid/out_ready out_t      index record out
//
// A byte is taken every cycle while it causes at most one record and the queue
// is not full; a byte that causes N records holds the input while the front
// end pushes them into the queue, one record per cycle while it is not full.
// Records pass from the queue into the output register that drives out_data.
// Reset is synchronous and active low and returns the parser to the start of a
// file. A stalled output fills the four-entry queue and then holds the input.
module csv_field_boundary_indexer_unit import cfbi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Records travel from the parser into the queue one word at a time.
  logic push, full;
  out_t push_data;

  cfbi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .full     (full),
    .push_data(push_data)
  );

  // The back end decouples the output handshake from parsing.
  cfbi_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .push_data(push_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for csv_field_boundary_indexer_unit: drives CSV
// bytes, predicts every index record and compares them. Depends on cfbi_pkg.
module tb_top;
  import cfbi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DELTA_W = 16;
  localparam int COL_LIMIT = 1024;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Idling percentages for the sender and the receiver.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  out_t expected_records[$];

  always #5 clk = ~clk;

  csv_field_boundary_indexer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Parser state of the predictor, held at the block's widths.
  logic [31:0] p_pos;
  logic        p_quoted;
  logic [7:0]  p_prev, p_prev2;
  logic [10:0] p_col, p_hdr_cols;
  logic        p_hdr_done;
  logic [1:0]  p_le_mode;
  logic        p_mode_pending;
  logic [31:0] p_anchor, p_row_base;
  logic [10:0] p_row_count;
  logic        p_skipping;
  logic [1:0]  p_flags;
  out_t        step_records[$];

  function automatic void reset_parser();
    p_pos = '0; p_quoted = 1'b0; p_prev = CH_LF; p_prev2 = '0;
    p_col = '0; p_hdr_cols = '0; p_hdr_done = 1'b0; p_le_mode = LEM_NONE;
    p_mode_pending = 1'b0; p_anchor = '0; p_row_base = '0; p_row_count = '0;
    p_skipping = 1'b0; p_flags = '0;
  endfunction

  function automatic void push_record(logic [1:0] kind, logic [31:0] pos,
                                      logic [10:0] col, logic [15:0] dlt,
                                      logic [10:0] rep, logic [31:0] base,
                                      logic [10:0] cnt);
    out_t r;
    r.kind = kind; r.position = pos; r.column = col; r.delta = dlt;
    r.repeat_res = rep; r.anchor_base = base; r.anchor_count = cnt;
    r.overflow_seen = p_flags[0]; r.underflow_seen = p_flags[1];
    r.last_result = 1'b0;
    if (step_records.size() < MAX_RES) step_records.push_back(r);
  endfunction

  // Emits a field offset, preceded by a fresh anchor when the delta is too wide.
  function automatic logic [15:0] put_offset(logic [31:0] val, logic [10:0] col);
    logic [31:0] gap;
    gap = val - p_anchor;
    if (gap > (32'd1 << DELTA_W) - 1) begin
      p_anchor = val;
      push_record(KIND_ANCHOR, val, col + 11'd1, '0, '0, '0, '0);
      p_row_count = p_row_count + 11'd1;
      gap = '0;
    end
    push_record(KIND_DELTA, '0, '0, gap[15:0], 11'd1, '0, '0);
    return gap[15:0];
  endfunction

  function automatic void close_row(logic [31:0] val);
    logic [15:0] d;
    d = '0;
    if (p_skipping) p_skipping = 1'b0;
    else d = put_offset(val, p_col);
    if (!p_hdr_done) begin
      p_hdr_cols = p_col;
      p_hdr_done = 1'b1;
    end else if (p_col < p_hdr_cols) begin
      p_flags[1] = 1'b1;
      push_record(KIND_DELTA, '0, '0, d, p_hdr_cols - p_col, '0, '0);
    end
    push_record(KIND_ROW, '0, '0, '0, '0, p_row_base, p_row_count);
    p_col = '0;
  endfunction

  // Works out the records one accepted byte causes and queues them.
  function automatic void predict_byte(in_t w);
    logic [7:0]  c;
    logic [31:0] i, val;
    logic [10:0] lim;
    logic        is_le, unq_le;
    logic [15:0] unused;
    c = w.data_byte;
    i = p_pos;
    is_le = (c == CH_CR) || (c == CH_LF);
    unq_le = is_le && !p_quoted;
    step_records.delete();
    p_pos = i + 32'd1;
    if (!(p_skipping && !is_le)) begin
      if (p_mode_pending) begin
        p_le_mode = (c == CH_LF) ? LEM_CRLF : LEM_CR;
        p_mode_pending = 1'b0;
      end
      if (p_col == 0 && !p_quoted && (p_prev == CH_LF || p_prev == CH_CR) &&
          p_prev2 != CH_CR) begin
        val = (p_le_mode == LEM_CRLF) ? i + 32'd1 : i;
        p_anchor = val;
        push_record(KIND_ANCHOR, val, '0, '0, '0, '0, '0);
        p_row_base = p_row_base + 32'(p_row_count);
        p_row_count = 11'd1;
        unused = put_offset(val, '0);
      end
      if (c == CH_QUOTE) begin
        p_quoted = !p_quoted;
      end else if (!p_quoted && c == CH_COMMA) begin
        lim = p_hdr_done ? p_hdr_cols : 11'(COL_LIMIT);
        unused = put_offset(i + 32'd1, p_col);
        if (p_col < lim) begin
          p_col = p_col + 11'd1;
        end else begin
          p_flags[0] = 1'b1;
          p_skipping = 1'b1;
        end
      end else if (!p_quoted && c == CH_LF && p_prev == CH_CR) begin
        // Second byte of a CRLF pair: nothing to do.
      end else if (unq_le) begin
        close_row(i + 32'd1);
        if (p_le_mode == LEM_NONE && !p_mode_pending) begin
          if (c == CH_LF) p_le_mode = LEM_LF;
          else p_mode_pending = 1'b1;
        end
      end
      p_prev2 = p_prev;
      p_prev = c;
    end
    if (w.end_of_file) begin
      if (!unq_le) close_row(i + 32'd2);
      reset_parser();
    end
    if (step_records.size() > 0) step_records[step_records.size() - 1].last_result = 1'b1;
    foreach (step_records[k]) expected_records.push_back(step_records[k]);
  endfunction

  // Sends one word, with a random idle gap first and valid held until taken.
  task automatic send_byte(logic [7:0] b, logic eof);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= '{data_byte: b, end_of_file: eof};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_byte('{data_byte: b, end_of_file: eof});
    @(negedge clk);
  endtask

  task automatic send_text(string s, logic eof_at_end);
    for (int k = 0; k < s.len(); k++)
      send_byte(s[k], eof_at_end && (k == s.len() - 1));
  endtask

  // Receiver: random stalls driven at the falling edge.
  always @(negedge clk)
    out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

  // Checker: compares every accepted record with the oldest expectation.
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        $error("record with none expected: %p", out_data);
        fail_count++;
      end else begin
        e = expected_records.pop_front();
        if (out_data.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_data.kind); fail_count++;
        end
        if (out_data.position !== e.position) begin
          $error("position: expected %0d, got %0d", e.position, out_data.position);
          fail_count++;
        end
        if (out_data.column !== e.column) begin
          $error("column: expected %0d, got %0d", e.column, out_data.column); fail_count++;
        end
        if (out_data.delta !== e.delta) begin
          $error("delta: expected %0d, got %0d", e.delta, out_data.delta); fail_count++;
        end
        if (out_data.repeat_res !== e.repeat_res) begin
          $error("repeat_res: expected %0d, got %0d", e.repeat_res, out_data.repeat_res);
          fail_count++;
        end
        if (out_data.anchor_base !== e.anchor_base) begin
          $error("anchor_base: expected %0d, got %0d", e.anchor_base, out_data.anchor_base);
          fail_count++;
        end
        if (out_data.anchor_count !== e.anchor_count) begin
          $error("anchor_count: expected %0d, got %0d", e.anchor_count,
                 out_data.anchor_count);
          fail_count++;
        end
        if (out_data.overflow_seen !== e.overflow_seen) begin
          $error("overflow_seen: expected %0d, got %0d", e.overflow_seen,
                 out_data.overflow_seen);
          fail_count++;
        end
        if (out_data.underflow_seen !== e.underflow_seen) begin
          $error("underflow_seen: expected %0d, got %0d", e.underflow_seen,
                 out_data.underflow_seen);
          fail_count++;
        end
        if (out_data.last_result !== e.last_result) begin
          $error("last_result: expected %0d, got %0d", e.last_result, out_data.last_result);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("csv_field_boundary_indexer_unit regression: fail");
      $finish;
    end
  end

  // Directed files: LF, CR and CRLF endings, quotes, short and long rows,
  // end of file without a line end, and every byte extreme.
  task automatic test_directed();
    send_text("a,b,c\nd,e\n", 1'b0);
    send_text("\"x,\ny\",1,2,3,4\n", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_text("p,q\rr,s\rt", 1'b1);
    send_text("h,i\r\nj\r\n", 1'b1);
  endtask

  // Random files with random line endings and content, including raw noise bytes.
  task automatic test_random_files(int n_bytes);
    int sent;
    int r;
    logic [7:0] b;
    string le;
    sent = 0;
    while (sent < n_bytes) begin
      case ($urandom_range(2))
        0: le = "\n";
        1: le = "\r";
        default: le = "\r\n";
      endcase
      for (int row = 0; row < $urandom_range(4, 1); row++) begin
        for (int f = 0; f < $urandom_range(4); f++) begin
          r = $urandom_range(99);
          if (r < 50) b = 8'd97 + 8'($urandom_range(25));
          else if (r < 65) b = CH_QUOTE;
          else if (r < 80) b = CH_COMMA;
          else if (r < 88) b = 8'($urandom_range(255));
          else b = 8'd49;
          send_byte(b, 1'b0); sent++;
          if ($urandom_range(3) == 0) begin
            send_byte(CH_COMMA, 1'b0); sent++;
          end
        end
        if ($urandom_range(9) == 0) begin
          send_byte($urandom_range(1) ? CH_LF : CH_CR, 1'b0); sent++;
        end else begin
          send_text(le, 1'b0); sent += le.len();
        end
      end
      send_byte(8'($urandom_range(255)), 1'b1); sent++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    reset_parser();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    drain();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random_files(100); drain();
    send_idle_pct = 52; recv_stall_pct = 0;  test_random_files(100); drain();
    send_idle_pct = 0;  recv_stall_pct = 52; test_random_files(100); drain();
    send_idle_pct = 25; recv_stall_pct = 25; test_random_files(100); drain();
    if (fail_count == 0) $display("csv_field_boundary_indexer_unit regression: pass");
    else $display("csv_field_boundary_indexer_unit regression: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/cfbi_pkg.sv
rtl/cfbi_front.sv
rtl/cfbi_back.sv
rtl/csv_field_boundary_indexer_unit.sv
tb/sv/tb_top.sv
